/* hdl/mpq_pkg.sv */
// Package for the multilevel priority queue: sizes, command codes, FSM states
// and the command record passed from the front end to the back end.
// No dependencies.
package mpq_pkg;

  localparam int STORE_DEPTH  = 64;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int NUM_LEVELS   = 5;
  localparam int LVL_W        = 3;
  localparam int PAYLOAD_BITS = 16;
  localparam int MAX_SERVE    = 64;
  localparam int CNT_W        = 7;
  localparam int FILL_W       = ADDR_W + 1;
  localparam int QDEPTH       = 2;

  typedef enum logic [1:0] {
    OP_ENQUEUE  = 2'd0,
    OP_ANNOUNCE = 2'd1,
    OP_PROMOTE  = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ENQ_POP,
    ST_ENQ_WR,
    ST_ENQ_LINK,
    ST_ANN_RD,
    ST_ANN_OUT
  } state_t;

  typedef struct packed {
    op_t                     op;
    logic [LVL_W-1:0]        level;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [CNT_W-1:0]        count;
  } cmd_t;

endpackage

/* hdl/mpq_ram.sv */
// Generic single write port RAM with registered read.
// No dependencies.
module mpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/mpq_front.sv */
// Front end: takes requests, decodes them and holds them in a two entry queue.
// Depends on mpq_pkg.
module mpq_front
  import mpq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_action,
  input  logic [LVL_W-1:0]        in_level,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  input  logic [CNT_W-1:0]        in_serve_count,
  output logic                    cmd_valid,
  output cmd_t                    cmd,
  input  logic                    cmd_pop
);

  cmd_t       q_r [QDEPTH];
  logic       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       dec;

  always_comb begin
    dec.op      = op_t'(in_action);
    dec.level   = in_level;
    dec.payload = in_payload;
    dec.count   = (in_serve_count > CNT_W'(MAX_SERVE)) ? CNT_W'(MAX_SERVE) : in_serve_count;
  end

  assign busy      = (cnt_r == 2'(QDEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = cmd_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= dec;
    end
  end

endmodule

/* hdl/mpq_back.sv */
// Back end: executes queued requests against the linked store.
// Depends on mpq_pkg and mpq_ram.
module mpq_back
  import mpq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cmd_valid,
  input  cmd_t                    cmd,
  output logic                    cmd_pop,
  output logic                    out_valid,
  output logic [PAYLOAD_BITS-1:0] out_item_payload,
  output logic [LVL_W-1:0]        out_item_level,
  output logic                    out_status,
  output logic                    out_last_flag
);

  state_t state_r, state_nxt;
  cmd_t   cur_r;

  logic [ADDR_W-1:0] head_r [NUM_LEVELS];
  logic [ADDR_W-1:0] tail_r [NUM_LEVELS];
  logic [FILL_W-1:0] fill_r [NUM_LEVELS];
  logic [ADDR_W-1:0] free_head_r;
  logic [FILL_W-1:0] free_fill_r;
  logic [FILL_W-1:0] fresh_r;
  logic [FILL_W-1:0] total_r;
  logic [ADDR_W-1:0] slot_r;
  logic [CNT_W-1:0]  rem_r;
  logic [LVL_W-1:0]  slvl_r;

  logic                    out_valid_r, out_status_r, out_last_r;
  logic [PAYLOAD_BITS-1:0] out_pay_r;
  logic [LVL_W-1:0]        out_lvl_r;

  // memory ports
  logic                    pay_we, lnk_we;
  logic [ADDR_W-1:0]       pay_waddr, lnk_waddr, pay_raddr, lnk_raddr;
  logic [PAYLOAD_BITS-1:0] pay_wdata, pay_rdata;
  logic [ADDR_W-1:0]       lnk_wdata, lnk_rdata;

  logic [LVL_W-1:0] first_lvl;
  logic             lvl_ok, lvl_busy, has_free, has_fresh, ann_last;

  mpq_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(STORE_DEPTH)) u_pay (
    .clk, .we(pay_we), .waddr(pay_waddr), .wdata(pay_wdata),
    .raddr(pay_raddr), .rdata(pay_rdata)
  );

  mpq_ram #(.WIDTH(ADDR_W), .DEPTH(STORE_DEPTH)) u_lnk (
    .clk, .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
    .raddr(lnk_raddr), .rdata(lnk_rdata)
  );

  // lowest non-empty level
  always_comb begin
    first_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (fill_r[i] != '0) begin
        first_lvl = LVL_W'(i);
      end
    end
  end

  assign lvl_ok    = (cur_r.level < LVL_W'(NUM_LEVELS));
  assign lvl_busy  = lvl_ok && (fill_r[cur_r.level] != '0);
  assign has_free  = (free_fill_r != '0);
  assign has_fresh = (fresh_r < FILL_W'(STORE_DEPTH));
  assign ann_last  = (rem_r == CNT_W'(1)) || (total_r == FILL_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        state_nxt = ST_IDLE;
        unique case (cur_r.op)
          OP_ENQUEUE: begin
            if (lvl_ok && has_free) state_nxt = ST_ENQ_POP;
            else if (lvl_ok && has_fresh) state_nxt = ST_ENQ_WR;
          end
          OP_ANNOUNCE: begin
            if (cur_r.count != '0 && total_r != '0) state_nxt = ST_ANN_RD;
          end
          OP_PROMOTE, OP_CLEAR: state_nxt = ST_IDLE;
        endcase
      end
      ST_ENQ_POP:  state_nxt = ST_ENQ_WR;
      ST_ENQ_WR:   state_nxt = lvl_busy ? ST_ENQ_LINK : ST_IDLE;
      ST_ENQ_LINK: state_nxt = ST_IDLE;
      ST_ANN_RD:   state_nxt = ST_ANN_OUT;
      ST_ANN_OUT:  state_nxt = ann_last ? ST_IDLE : ST_ANN_RD;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // memory control and queue pop
  always_comb begin
    cmd_pop   = (state_r == ST_IDLE) && cmd_valid;
    pay_we    = 1'b0;
    pay_waddr = slot_r;
    pay_wdata = cur_r.payload;
    pay_raddr = head_r[first_lvl];
    lnk_we    = 1'b0;
    lnk_waddr = slot_r;
    lnk_wdata = '0;
    lnk_raddr = head_r[first_lvl];
    unique case (state_r)
      ST_DECODE: begin
        lnk_raddr = free_head_r;
        if (cur_r.op == OP_PROMOTE && fill_r[1] != '0 && fill_r[0] != '0) begin
          lnk_we    = 1'b1;
          lnk_waddr = tail_r[0];
          lnk_wdata = head_r[1];
        end
      end
      ST_ENQ_WR: begin
        pay_we = 1'b1;
        lnk_we = 1'b1;
      end
      ST_ENQ_LINK: begin
        lnk_we    = 1'b1;
        lnk_waddr = tail_r[cur_r.level];
        lnk_wdata = slot_r;
      end
      ST_ANN_OUT: begin
        lnk_we    = 1'b1;
        lnk_waddr = slot_r;
        lnk_wdata = free_head_r;
      end
      ST_IDLE, ST_ENQ_POP, ST_ANN_RD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        fill_r[i] <= '0;
      end
      free_head_r <= '0;
      free_fill_r <= '0;
      fresh_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_valid) cur_r <= cmd;
        end
        ST_DECODE: begin
          rem_r <= cur_r.count;
          unique case (cur_r.op)
            OP_ENQUEUE: begin
              if (lvl_ok && has_free) begin
                slot_r <= free_head_r;
              end else if (lvl_ok && has_fresh) begin
                slot_r  <= fresh_r[ADDR_W-1:0];
                fresh_r <= fresh_r + FILL_W'(1);
              end else if (lvl_ok) begin
                out_valid_r  <= 1'b1;
                out_pay_r    <= cur_r.payload;
                out_lvl_r    <= cur_r.level;
                out_status_r <= 1'b1;
                out_last_r   <= 1'b1;
              end
            end
            OP_ANNOUNCE: ;
            OP_PROMOTE: begin
              if (fill_r[1] != '0) begin
                if (fill_r[0] == '0) head_r[0] <= head_r[1];
                tail_r[0] <= tail_r[1];
                fill_r[0] <= fill_r[0] + fill_r[1];
              end
              for (int i = 1; i < NUM_LEVELS - 1; i++) begin
                head_r[i] <= head_r[i+1];
                tail_r[i] <= tail_r[i+1];
                fill_r[i] <= fill_r[i+1];
              end
              head_r[NUM_LEVELS-1] <= '0;
              tail_r[NUM_LEVELS-1] <= '0;
              fill_r[NUM_LEVELS-1] <= '0;
            end
            OP_CLEAR: begin
              for (int i = 0; i < NUM_LEVELS; i++) begin
                head_r[i] <= '0;
                tail_r[i] <= '0;
                fill_r[i] <= '0;
              end
              free_head_r <= '0;
              free_fill_r <= '0;
              fresh_r     <= '0;
              total_r     <= '0;
            end
          endcase
        end
        ST_ENQ_POP: begin
          free_head_r <= lnk_rdata;
          free_fill_r <= free_fill_r - FILL_W'(1);
        end
        ST_ENQ_WR: begin
          if (!lvl_busy) begin
            head_r[cur_r.level] <= slot_r;
            tail_r[cur_r.level] <= slot_r;
            fill_r[cur_r.level] <= fill_r[cur_r.level] + FILL_W'(1);
            total_r             <= total_r + FILL_W'(1);
          end
        end
        ST_ENQ_LINK: begin
          tail_r[cur_r.level] <= slot_r;
          fill_r[cur_r.level] <= fill_r[cur_r.level] + FILL_W'(1);
          total_r             <= total_r + FILL_W'(1);
        end
        ST_ANN_RD: begin
          slot_r <= head_r[first_lvl];
          slvl_r <= first_lvl;
        end
        ST_ANN_OUT: begin
          out_valid_r    <= 1'b1;
          out_pay_r      <= pay_rdata;
          out_lvl_r      <= slvl_r;
          out_status_r   <= 1'b0;
          out_last_r     <= ann_last;
          head_r[slvl_r] <= lnk_rdata;
          fill_r[slvl_r] <= fill_r[slvl_r] - FILL_W'(1);
          total_r        <= total_r - FILL_W'(1);
          free_head_r    <= slot_r;
          free_fill_r    <= free_fill_r + FILL_W'(1);
          rem_r          <= rem_r - CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_item_payload = out_pay_r;
  assign out_item_level   = out_lvl_r;
  assign out_status       = out_status_r;
  assign out_last_flag    = out_last_r;

endmodule

/* hdl/multilevel_priority_queue_promote_core.sv */
// Top level of the multilevel priority queue: front end queue plus back end.
// Depends on mpq_pkg, mpq_front, mpq_back.

// Requests are taken when start is high and busy is low; up to two requests
// wait in a queue while earlier ones run. In the back end an enqueue passes
// through decode, a pop of the free list when it uses a recycled entry, the
// write, and a link step when its level already holds items; a dropped or
// ignored enqueue, promote and clear end after decode, and announce runs a
// read and an output step per item served, set by the registered read of the
// link memory. Results appear for exactly one cycle on out_valid and cannot be
// held off. No clearing pass is needed after reset.
module multilevel_priority_queue_promote_core
  import mpq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_action,
  input  logic [LVL_W-1:0]        in_level,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  input  logic [CNT_W-1:0]        in_serve_count,
  output logic                    out_valid,
  output logic [PAYLOAD_BITS-1:0] out_item_payload,
  output logic [LVL_W-1:0]        out_item_level,
  output logic                    out_status,
  output logic                    out_last_flag
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  mpq_front u_front (
    .clk, .rst_n, .start, .busy, .in_action, .in_level, .in_payload,
    .in_serve_count, .cmd_valid, .cmd, .cmd_pop
  );

  mpq_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_pop, .out_valid, .out_item_payload,
    .out_item_level, .out_status, .out_last_flag
  );

endmodule

/* hdl/mpq_checker.sv */
// Port-level checks for the multilevel priority queue, bound to the top level.
// Depends on mpq_pkg.
module mpq_checker
  import mpq_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic [LVL_W-1:0] out_item_level,
  input logic             out_status,
  input logic             out_last_flag
);

  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last_flag)
    else $error("drop result without last flag");

  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results in consecutive cycles");

  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item_level < LVL_W'(NUM_LEVELS))
    else $error("result level out of range");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

endmodule

bind multilevel_priority_queue_promote_core mpq_checker u_mpq_checker (
  .clk, .rst_n, .out_valid, .out_item_level, .out_status, .out_last_flag
);
